### rtl/mttp_pkg.sv
// Shared types and codes for the multi-timebase timer pool.
// Used by mttp_cell, the top level and the testbench; depends on nothing.
package mttp_pkg;

  // Item kinds
  localparam logic [1:0] KIND_SUB   = 2'd0;
  localparam logic [1:0] KIND_UNSUB = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Timebase code that names no timebase
  localparam logic [1:0] BASE_NONE  = 2'd3;

  // One beat walking down the row of cells
  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [1:0]  base;
    logic        periodic;
    logic [31:0] period;
    logic [3:0]  sidx;
    logic [7:0]  tag;
    logic [3:0]  id4;         // id handed to the slot that takes a subscribe
    logic        sub_ok;      // subscribe passed its checks
    logic        done;        // slot taken or slot freed
    logic [3:0]  res_slot;    // slot that took the subscribe
    logic        pend_valid;  // an expiry waits to be reported
    logic [3:0]  pend_slot;
    logic [3:0]  pend_id;
    logic [7:0]  pend_tag;
  } beat_t;

  // One result beat
  typedef struct packed {
    logic       status;
    logic       fired;
    logic [3:0] slot;
    logic [3:0] id;
    logic [7:0] tag;
    logic       last;
  } res_t;

endpackage

### rtl/multi_timebase_timer_pool_top.sv
// Top level of the multi-timebase timer pool: a row of SLOTS slot cells
// walked by one command beat. Depends on mttp_pkg and mttp_cell.
//
//  channel   handshake                  payload
//  command   start, busy (accept: start & !busy)
//            kind_i, timebase_i, periodic_i, period_i, slot_index_i, handler_tag_i
//  result    result_valid_o (one cycle) status_o, fired_o, slot_out_o, timer_id_o,
//                                       tag_out_o, last_o
//
// A command beat enters a register, then visits one slot cell per cycle.
// The final result is registered as the beat leaves the row; busy stays high
// until then, so a new command is taken only after the last one has left it.
// Expiries of a tick come out as the beat passes the following expiring slot,
// the last one when the beat leaves the row. Reset frees every slot at once.
// Results cannot be held off and are never stalled.
module multi_timebase_timer_pool_top #(
  parameter int unsigned SLOTS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  timebase_i,
  input  logic        periodic_i,
  input  logic [31:0] period_i,
  input  logic [3:0]  slot_index_i,
  input  logic [7:0]  handler_tag_i,
  output logic        result_valid_o,
  output logic        status_o,
  output logic        fired_o,
  output logic [3:0]  slot_out_o,
  output logic [3:0]  timer_id_o,
  output logic [7:0]  tag_out_o,
  output logic        last_o
);

  localparam int unsigned IdW = $clog2(SLOTS + 1);

  logic            accept, sub_ok, free_any, chain_busy;
  logic [IdW-1:0]  total_q;
  logic [31:0]     id_next;
  mttp_pkg::beat_t head_q, tail;
  mttp_pkg::beat_t cell_in  [SLOTS];
  mttp_pkg::beat_t cell_out [SLOTS];
  logic            cell_emit [SLOTS];
  mttp_pkg::res_t  cell_res  [SLOTS];
  logic            cell_free [SLOTS];
  logic            res_valid_d, res_valid_q;
  mttp_pkg::res_t  res_d, res_q;

  assign accept  = start && !busy;
  assign id_next = 32'(total_q) + 32'd1;
  assign sub_ok  = (handler_tag_i != 8'd0) && (period_i != 32'd0) &&
                   (timebase_i != mttp_pkg::BASE_NONE) && (32'(total_q) < SLOTS);

  // Capture the command beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else if (accept) begin
      head_q <= '{valid: 1'b1, kind: kind_i, base: timebase_i, periodic: periodic_i,
                  period: period_i, sidx: slot_index_i, tag: handler_tag_i,
                  id4: id_next[3:0], sub_ok: sub_ok, done: 1'b0, res_slot: 4'd0,
                  pend_valid: 1'b0, pend_slot: 4'd0, pend_id: 4'd0, pend_tag: 8'd0};
    end else begin
      head_q <= '0;
    end
  end

  // Row of slot cells
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign cell_in[g] = head_q;
    end else begin : g_next
      assign cell_in[g] = cell_out[g-1];
    end
    mttp_cell #(.IDX(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .beat_i (cell_in[g]),
      .beat_o (cell_out[g]),
      .emit_o (cell_emit[g]),
      .res_o  (cell_res[g]),
      .free_o (cell_free[g])
    );
  end

  assign tail = cell_out[SLOTS-1];

  // Gather per-cell pulses; only one cell holds the beat at a time
  always_comb begin
    free_any   = 1'b0;
    chain_busy = head_q.valid;
    for (int i = 0; i < SLOTS; i++) begin
      free_any   = free_any | cell_free[i];
      chain_busy = chain_busy | cell_out[i].valid;
    end
  end

  assign busy = chain_busy;

  // Active slot count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (accept && kind_i == mttp_pkg::KIND_SUB && sub_ok) begin
      total_q <= total_q + IdW'(1);
    end else if (free_any) begin
      total_q <= total_q - IdW'(1);
    end
  end

  // Pick the result of this cycle: an expiry from a cell, or the final beat
  always_comb begin
    res_valid_d = 1'b0;
    res_d       = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (cell_emit[i]) begin
        res_valid_d = 1'b1;
        res_d       = cell_res[i];
      end
    end
    if (tail.valid) begin
      res_valid_d = 1'b1;
      res_d       = '0;
      res_d.last  = 1'b1;
      case (tail.kind)
        mttp_pkg::KIND_SUB: begin
          res_d.status = !tail.done;
          if (tail.done) begin
            res_d.slot = tail.res_slot;
            res_d.id   = tail.id4;
          end
        end
        mttp_pkg::KIND_UNSUB: begin
          res_d.status = !tail.done;
        end
        mttp_pkg::KIND_TICK: begin
          if (tail.base == mttp_pkg::BASE_NONE) begin
            res_d.status = 1'b1;
          end else if (tail.pend_valid) begin
            res_d.fired = 1'b1;
            res_d.slot  = tail.pend_slot;
            res_d.id    = tail.pend_id;
            res_d.tag   = tail.pend_tag;
          end
        end
        default: begin
          res_d.status = 1'b1;
        end
      endcase
    end
  end

  // Register the result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = res_q.status;
  assign fired_o        = res_q.fired;
  assign slot_out_o     = res_q.slot;
  assign timer_id_o     = res_q.id;
  assign tag_out_o      = res_q.tag;
  assign last_o         = res_q.last;

endmodule

### rtl/mttp_cell.sv
// One timer slot of the pool and its stage of the beat chain.
// Depends on mttp_pkg.
module mttp_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mttp_pkg::beat_t beat_i,
  output mttp_pkg::beat_t beat_o,
  output logic            emit_o,
  output mttp_pkg::res_t  res_o,
  output logic            free_o
);

  localparam logic [3:0] SLOT4 = IDX[3:0];

  logic        active_q;
  logic [1:0]  base_q;
  logic        periodic_q;
  logic [31:0] period_q;
  logic [31:0] count_q;
  logic [7:0]  tag_q;
  logic [3:0]  id_q;

  mttp_pkg::beat_t beat_d, beat_q;
  logic take, reload, dec, idx_hit;

  assign idx_hit = ({28'd0, beat_i.sidx} == IDX);

  // Act on the beat passing this slot
  always_comb begin
    beat_d = beat_i;
    emit_o = 1'b0;
    res_o  = '0;
    free_o = 1'b0;
    take   = 1'b0;
    reload = 1'b0;
    dec    = 1'b0;
    if (beat_i.valid) begin
      case (beat_i.kind)
        mttp_pkg::KIND_SUB: begin
          if (beat_i.sub_ok && !beat_i.done && !active_q) begin
            take            = 1'b1;
            beat_d.done     = 1'b1;
            beat_d.res_slot = SLOT4;
          end
        end
        mttp_pkg::KIND_UNSUB: begin
          if (active_q && idx_hit && tag_q == beat_i.tag && base_q == beat_i.base) begin
            free_o      = 1'b1;
            beat_d.done = 1'b1;
          end
        end
        mttp_pkg::KIND_TICK: begin
          if (active_q && base_q == beat_i.base) begin
            if (count_q[31:1] == 31'd0) begin
              if (periodic_q) begin
                reload = 1'b1;
              end else begin
                free_o = 1'b1;
              end
              // release the expiry held so far, hold this one
              if (beat_i.pend_valid) begin
                emit_o = 1'b1;
                res_o  = '{status: 1'b0, fired: 1'b1, slot: beat_i.pend_slot,
                           id: beat_i.pend_id, tag: beat_i.pend_tag, last: 1'b0};
              end
              beat_d.pend_valid = 1'b1;
              beat_d.pend_slot  = SLOT4;
              beat_d.pend_id    = id_q;
              beat_d.pend_tag   = tag_q;
            end else begin
              dec = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Slot occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (take) begin
      active_q <= 1'b1;
    end else if (free_o) begin
      active_q <= 1'b0;
    end
  end

  // Slot contents and countdown
  always_ff @(posedge clk_i) begin
    if (take) begin
      base_q     <= beat_i.base;
      periodic_q <= beat_i.periodic;
      period_q   <= beat_i.period;
      count_q    <= beat_i.period;
      tag_q      <= beat_i.tag;
      id_q       <= beat_i.id4;
    end else if (reload) begin
      count_q <= period_q;
    end else if (dec) begin
      count_q <= count_q - 32'd1;
    end
  end

  // Hand the beat to the next slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else begin
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

### rtl/mttp_checker.sv
// Port-level checks for the timer pool, bound to the top level.
// Depends only on the ports of multi_timebase_timer_pool_top.
module mttp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       result_valid_o,
  input logic       status_o,
  input logic       fired_o,
  input logic       last_o
);

  // An accepted command keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy low right after an accepted command");

  // No result beat can follow an accept immediately
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !result_valid_o)
    else $error("result beat one cycle after accept");

  // Only expiries come ahead of the final beat
  a_nonlast_is_expiry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> fired_o)
    else $error("non-final result beat that is not an expiry");

  // An expiry is never a refusal
  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && fired_o |-> !status_o)
    else $error("expiry beat with error status");

endmodule

bind multi_timebase_timer_pool_top mttp_checker u_mttp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .fired_o        (fired_o),
  .last_o         (last_o)
);

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the multi-timebase timer pool top level.
// Drives command beats through start/busy, predicts every result beat and
// compares field by field; depends on mttp_pkg and multi_timebase_timer_pool_top.
module testbench;

  localparam int unsigned SLOTS      = 12;
  localparam int unsigned QUIET_MAX  = 400;
  localparam int unsigned TAIL_CALM  = 60;
  localparam int unsigned RAND_ITEMS = 410;
  localparam logic [1:0]  KIND_NONE  = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [1:0]  base;
    logic        periodic;
    logic [31:0] period;
    logic [3:0]  sidx;
    logic [7:0]  tag;
    int          gap;    // idle cycles before this beat is offered
    bit          drain;  // hold this beat until every result has come
  } cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind_i = '0;
  logic [1:0]  timebase_i = '0;
  logic        periodic_i = 1'b0;
  logic [31:0] period_i = '0;
  logic [3:0]  slot_index_i = '0;
  logic [7:0]  handler_tag_i = '0;
  logic        result_valid_o;
  logic        status_o;
  logic        fired_o;
  logic [3:0]  slot_out_o;
  logic [3:0]  timer_id_o;
  logic [7:0]  tag_out_o;
  logic        last_o;

  // Shadow copy of the pool
  logic [3:0]  pool_id       [SLOTS];
  logic [1:0]  pool_base     [SLOTS];
  logic        pool_periodic [SLOTS];
  logic [31:0] pool_period   [SLOTS];
  logic [31:0] pool_count    [SLOTS];
  logic [7:0]  pool_tag      [SLOTS];
  logic [3:0]  live_total;
  logic [3:0]  live_per_base [3];

  cmd_t cmd_queue[$];
  mttp_pkg::res_t due_results[$];
  cmd_t cur_cmd;
  int   mismatches = 0;
  int   quiet_cycles = 0;
  bit   calm = 0;
  bit   bursty = 0;

  multi_timebase_timer_pool_top #(.SLOTS(SLOTS)) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .timebase_i     (timebase_i),
    .periodic_i     (periodic_i),
    .period_i       (period_i),
    .slot_index_i   (slot_index_i),
    .handler_tag_i  (handler_tag_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .fired_o        (fired_o),
    .slot_out_o     (slot_out_o),
    .timer_id_o     (timer_id_o),
    .tag_out_o      (tag_out_o),
    .last_o         (last_o)
  );

  // Toggle the clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Update the shadow pool with one command and queue the beats it causes
  task automatic apply_command(input cmd_t c);
    mttp_pkg::res_t r;
    int   i;
    bit   found;
    int   n;
    r = '0;
    found = 0;
    n = 0;
    case (c.kind)
      mttp_pkg::KIND_SUB: begin
        if (c.tag != 0 && c.period != 0 && c.base != mttp_pkg::BASE_NONE &&
            live_total < SLOTS) begin
          for (i = 0; i < SLOTS; i++) begin
            if (!found && pool_id[i] == 0) begin
              found = 1;
              live_total = live_total + 4'd1;
              pool_id[i] = live_total;
              pool_base[i] = c.base;
              pool_periodic[i] = c.periodic;
              pool_period[i] = c.period;
              pool_count[i] = c.period;
              pool_tag[i] = c.tag;
              live_per_base[c.base] = live_per_base[c.base] + 4'd1;
              r.slot = i[3:0];
              r.id = pool_id[i];
            end
          end
        end
        r.status = !found;
        r.last = 1'b1;
        due_results.push_back(r);
      end
      mttp_pkg::KIND_UNSUB: begin
        if (c.tag != 0 && c.base != mttp_pkg::BASE_NONE && c.sidx < SLOTS &&
            live_total > 0 && live_per_base[c.base] > 0 && pool_id[c.sidx] != 0 &&
            pool_tag[c.sidx] == c.tag && pool_base[c.sidx] == c.base) begin
          // Clear the slot but keep its timebase
          pool_id[c.sidx] = '0;
          pool_periodic[c.sidx] = 1'b0;
          pool_period[c.sidx] = '0;
          pool_count[c.sidx] = '0;
          pool_tag[c.sidx] = '0;
          live_total = live_total - 4'd1;
          live_per_base[c.base] = live_per_base[c.base] - 4'd1;
          found = 1;
        end
        r.status = !found;
        r.last = 1'b1;
        due_results.push_back(r);
      end
      mttp_pkg::KIND_TICK: begin
        if (c.base == mttp_pkg::BASE_NONE) begin
          r.status = 1'b1;
          r.last = 1'b1;
          due_results.push_back(r);
        end else begin
          if (live_total > 0 && live_per_base[c.base] > 0) begin
            for (i = 0; i < SLOTS; i++) begin
              if (pool_id[i] != 0 && pool_base[i] == c.base) begin
                if (pool_count[i] <= 32'd1) begin
                  r = '0;
                  r.fired = 1'b1;
                  r.slot = i[3:0];
                  r.id = pool_id[i];
                  r.tag = pool_tag[i];
                  if (!pool_periodic[i]) begin
                    pool_id[i] = '0;
                    if (live_total > 0) live_total = live_total - 4'd1;
                    if (live_per_base[c.base] > 0)
                      live_per_base[c.base] = live_per_base[c.base] - 4'd1;
                  end else begin
                    pool_count[i] = pool_period[i];
                  end
                  due_results.push_back(r);
                  n++;
                end else begin
                  pool_count[i] = pool_count[i] - 32'd1;
                end
              end
            end
          end
          if (n == 0) begin
            r = '0;
            r.last = 1'b1;
            due_results.push_back(r);
          end else begin
            due_results[due_results.size() - 1].last = 1'b1;
          end
        end
      end
      default: begin
        r.status = 1'b1;
        r.last = 1'b1;
        due_results.push_back(r);
      end
    endcase
  endtask

  // Drive command beats from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin
    bit take;
    bit nxt_start;
    if (!rst_ni) begin
      start <= 1'b0;
      kind_i <= '0;
      timebase_i <= '0;
      periodic_i <= 1'b0;
      period_i <= '0;
      slot_index_i <= '0;
      handler_tag_i <= '0;
    end else begin
      take = start && !busy;
      if (take) apply_command(cur_cmd);
      // Hold the beat while the block is busy
      if (!start || take) begin
        nxt_start = 1'b0;
        if (cmd_queue.size() != 0) begin
          if (cmd_queue[0].gap > 0) begin
            cmd_queue[0].gap = cmd_queue[0].gap - 1;
          end else if (!(cmd_queue[0].drain && due_results.size() != 0)) begin
            cur_cmd = cmd_queue.pop_front();
            kind_i <= cur_cmd.kind;
            timebase_i <= cur_cmd.base;
            periodic_i <= cur_cmd.periodic;
            period_i <= cur_cmd.period;
            slot_index_i <= cur_cmd.sidx;
            handler_tag_i <= cur_cmd.tag;
            nxt_start = 1'b1;
          end
        end
        start <= nxt_start;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    mttp_pkg::res_t want;
    if (rst_ni && result_valid_o) begin
      if (due_results.size() == 0) begin
        $error("result beat with no prediction outstanding");
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("fired", 32'(want.fired), 32'(fired_o));
        check_field("slot_out", 32'(want.slot), 32'(slot_out_o));
        check_field("timer_id", 32'(want.id), 32'(timer_id_o));
        check_field("tag_out", 32'(want.tag), 32'(tag_out_o));
        check_field("last", 32'(want.last), 32'(last_o));
      end
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic cmd_t make_cmd(input logic [1:0] kind, input logic [1:0] base,
                                    input logic periodic, input logic [31:0] period,
                                    input logic [3:0] sidx, input logic [7:0] tag);
    cmd_t c;
    c.kind = kind;
    c.base = base;
    c.periodic = periodic;
    c.period = period;
    c.sidx = sidx;
    c.tag = tag;
    c.gap = 0;
    c.drain = 0;
    return c;
  endfunction

  // Add an idle burst if the stream is in a bursty stretch, then queue the beat
  task automatic queue_cmd(input cmd_t c);
    while (cmd_queue.size() >= 2) @(posedge clk_i);
    if ($urandom_range(0, 19) == 0) bursty = !bursty;
    if (!calm && bursty && $urandom_range(0, 1) == 0) c.gap = $urandom_range(1, 19);
    cmd_queue.push_back(c);
  endtask

  function automatic logic [31:0] draw_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(1, 4);
    if (r < 80) return $urandom_range(5, 24);
    return $urandom();
  endfunction

  initial begin
    cmd_t c;
    int   k;
    int   r;
    int   i;
    int   live[$];
    for (i = 0; i < SLOTS; i++) begin
      pool_id[i] = '0;
      pool_base[i] = '0;
      pool_periodic[i] = 1'b0;
      pool_period[i] = '0;
      pool_count[i] = '0;
      pool_tag[i] = '0;
    end
    live_total = '0;
    for (i = 0; i < 3; i++) live_per_base[i] = '0;

    // Hold reset, then release it at a falling clock edge
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: refusals, both modes, field extremes, every kind
    queue_cmd(make_cmd(mttp_pkg::KIND_TICK, 2'd0, 1'b0, 32'd0, 4'd0, 8'd0));
    queue_cmd(make_cmd(mttp_pkg::KIND_SUB, 2'd0, 1'b0, 32'd5, 4'd0, 8'd0));
    queue_cmd(make_cmd(mttp_pkg::KIND_SUB, 2'd0, 1'b1, 32'd0, 4'd0, 8'd1));
    queue_cmd(make_cmd(mttp_pkg::KIND_SUB, mttp_pkg::BASE_NONE, 1'b0, 32'd5, 4'd0, 8'd9));
    queue_cmd(make_cmd(mttp_pkg::KIND_SUB, 2'd0, 1'b0, 32'd1, 4'd0, 8'hFF));
    queue_cmd(make_cmd(mttp_pkg::KIND_SUB, 2'd0, 1'b1, 32'd2, 4'd0, 8'h01));
    queue_cmd(make_cmd(mttp_pkg::KIND_SUB, 2'd1, 1'b1, 32'hFFFF_FFFF, 4'd15, 8'h80));
    queue_cmd(make_cmd(mttp_pkg::KIND_SUB, 2'd2, 1'b0, 32'd3, 4'd0, 8'h55));
    queue_cmd(make_cmd(mttp_pkg::KIND_TICK, 2'd0, 1'b0, 32'd0, 4'd0, 8'd0));
    queue_cmd(make_cmd(mttp_pkg::KIND_TICK, 2'd0, 1'b0, 32'd0, 4'd0, 8'd0));
    queue_cmd(make_cmd(mttp_pkg::KIND_TICK, mttp_pkg::BASE_NONE, 1'b0, 32'd0, 4'd0, 8'd0));
    queue_cmd(make_cmd(KIND_NONE, mttp_pkg::BASE_NONE, 1'b1, 32'hFFFF_FFFF, 4'd15, 8'hFF));
    queue_cmd(make_cmd(mttp_pkg::KIND_UNSUB, 2'd1, 1'b0, 32'd0, 4'd2, 8'h00));
    queue_cmd(make_cmd(mttp_pkg::KIND_UNSUB, 2'd1, 1'b0, 32'd0, 4'd2, 8'h81));
    queue_cmd(make_cmd(mttp_pkg::KIND_UNSUB, 2'd0, 1'b0, 32'd0, 4'd2, 8'h80));
    queue_cmd(make_cmd(mttp_pkg::KIND_UNSUB, 2'd1, 1'b0, 32'd0, 4'd15, 8'h80));
    queue_cmd(make_cmd(mttp_pkg::KIND_UNSUB, 2'd0, 1'b0, 32'd0, 4'd0, 8'hFF));
    queue_cmd(make_cmd(mttp_pkg::KIND_UNSUB, mttp_pkg::BASE_NONE, 1'b0, 32'd0, 4'd3, 8'h55));
    queue_cmd(make_cmd(mttp_pkg::KIND_UNSUB, 2'd1, 1'b0, 32'd0, 4'd2, 8'h80));
    queue_cmd(make_cmd(mttp_pkg::KIND_TICK, 2'd2, 1'b0, 32'd0, 4'd0, 8'd0));
    queue_cmd(make_cmd(mttp_pkg::KIND_TICK, 2'd1, 1'b0, 32'd0, 4'd0, 8'd0));

    // Random: fill the pool first, then a mix of well-formed beats and noise
    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k == RAND_ITEMS - TAIL_CALM) calm = 1;
      r = $urandom_range(0, 99);
      if (k < 16) begin
        c = make_cmd(mttp_pkg::KIND_SUB, 2'($urandom_range(0, 2)),
                     1'($urandom_range(0, 1)), 32'($urandom_range(20, 5000)),
                     4'($urandom_range(0, 15)), 8'($urandom_range(1, 255)));
      end else if (r < 35) begin
        c = make_cmd(mttp_pkg::KIND_SUB, 2'($urandom_range(0, 2)),
                     1'($urandom_range(0, 1)), draw_period(),
                     4'($urandom_range(0, 15)), 8'($urandom_range(1, 255)));
      end else if (r < 52) begin
        live.delete();
        for (i = 0; i < SLOTS; i++) if (pool_id[i] != 0) live.push_back(i);
        if (live.size() != 0 && $urandom_range(0, 3) != 0) begin
          i = live[$urandom_range(0, live.size() - 1)];
          c = make_cmd(mttp_pkg::KIND_UNSUB, pool_base[i], 1'($urandom_range(0, 1)),
                       $urandom(), i[3:0], pool_tag[i]);
        end else begin
          c = make_cmd(mttp_pkg::KIND_UNSUB, 2'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1)), $urandom(),
                       4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        end
      end else if (r < 92) begin
        c = make_cmd(mttp_pkg::KIND_TICK, 2'($urandom_range(0, 2)),
                     1'($urandom_range(0, 1)), $urandom(),
                     4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      end else begin
        c = make_cmd(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)), $urandom(),
                     4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      end
      // Let the pool settle completely now and then
      if (k == 0 || k == 150 || k == 300) c.drain = 1;
      queue_cmd(c);
    end

    // Drain the stimulus and the outstanding results
    while (cmd_queue.size() != 0 || start) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 8) @(posedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
